>>> rtl/core/tlpt_pkg.sv
`default_nettype none

package tlpt_pkg;

  // virtual address split
  localparam int IDX_W     = 10;
  localparam int OFFS_W    = 12;
  localparam int FRAME_W   = 20;
  localparam int DIR_MSB   = 31;
  localparam int TBL_MSB   = 21;

  localparam int DIR_ENTRIES       = 1024;
  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int POOL_TABLES_DEF   = 16;

  // operation codes carried in tuser
  localparam logic KIND_MAP       = 1'b0;
  localparam logic KIND_TRANSLATE = 1'b1;

  // configuration register indexes
  localparam logic REG_POOL_FRAME = 1'b0;

  // stored entry: present bit above the frame number
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
  } tlpt_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR,
    ST_TBL,
    ST_DONE
  } tlpt_state_t;

endpackage

`default_nettype wire

>>> rtl/core/two_level_page_table_engine.sv
`default_nettype none

// channel  | dir | ports            | beat contents
// ---------+-----+------------------+------------------------------------------
// in       | in  | in_t*            | tuser: kind; tdata: virt, phys, flags
// out      | out | out_t*           | tdata: result_addr, is_present, pool_full
// cfg      | in  | cfg_p*           | apb, reg 0 at 0x0: table_pool_frame
//
// a translate that reaches a pool table goes through the directory read, then the
// dependent pool table read, then the result stage before the next accept; a map,
// or a translate that stops at the directory, skips the pool table read.
// after reset both memories are zeroed one word a cycle, with in_tready low;
// config writes are taken meanwhile.
// a finished result waits in the output register while the next beat comes in;
// a held result stalls only the result stage of the following item.

module two_level_page_table_engine
  import tlpt_pkg::*;
#(
  parameter int POOL_TABLES = POOL_TABLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // virt_addr[31:0], phys_addr[63:32], page_flags[75:64]
  input  wire logic        in_tuser,   // kind
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // result_addr[31:0], is_present[32], pool_full[33]
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int SLOT_W     = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int CNT_W      = $clog2(POOL_TABLES + 1);
  localparam int PA_W       = SLOT_W + IDX_W;
  localparam int POOL_WORDS = POOL_TABLES * ENTRIES_PER_TABLE;
  localparam int ENTRY_W    = FRAME_W + 1;

  // memories
  tlpt_entry_t dir_mem  [DIR_ENTRIES];
  tlpt_entry_t pool_mem [POOL_WORDS];

  tlpt_entry_t dir_rdata_r;
  tlpt_entry_t pool_rdata_r;

  logic              dir_we;
  logic [IDX_W-1:0]  dir_waddr;
  logic [IDX_W-1:0]  dir_raddr;
  tlpt_entry_t       dir_wdata;
  logic              pool_we;
  logic [PA_W-1:0]   pool_waddr;
  logic [PA_W-1:0]   pool_raddr;
  tlpt_entry_t       pool_wdata;

  // control and item registers
  tlpt_state_t         state_r, state_nxt;
  logic [PA_W-1:0]     clr_r, clr_nxt;
  logic [CNT_W-1:0]    next_slot_r, next_slot_nxt;
  logic [FRAME_W-1:0]  pool_frame_r;

  logic                kind_r;
  // directory index of the item in flight
  logic [IDX_W-1:0]    dir_raddr_r;
  logic [IDX_W-1:0]    tidx_r;
  logic [OFFS_W-1:0]   offs_r;
  logic [FRAME_W-1:0]  pfn_r;
  logic                pflag_r;

  logic [31:0]         res_addr_r, res_addr_nxt;
  logic                res_present_r, res_present_nxt;
  logic                res_full_r, res_full_nxt;

  logic                out_valid_r;
  logic [31:0]         out_addr_r;
  logic                out_present_r;
  logic                out_full_r;

  logic                in_beat;
  logic                out_load;
  logic                cfg_wr;
  logic                clr_last;
  logic [FRAME_W-1:0]  slot_diff;
  logic                slot_ok;
  logic                pool_empty;
  logic [FRAME_W-1:0]  new_frame;

  assign in_beat  = in_tvalid && in_tready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign clr_last = (clr_r == PA_W'(POOL_WORDS - 1));

  // pool slot named by the directory entry just read
  assign slot_diff  = dir_rdata_r.frame - pool_frame_r;
  assign slot_ok    = (slot_diff < FRAME_W'(POOL_TABLES));
  assign pool_empty = (next_slot_r == CNT_W'(POOL_TABLES));
  assign new_frame  = pool_frame_r + FRAME_W'(next_slot_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_beat) state_nxt = ST_DIR;
      ST_DIR: begin
        if (kind_r == KIND_TRANSLATE && dir_rdata_r.present && slot_ok) begin
          state_nxt = ST_TBL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_TBL:   state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // memory controls and result
  always_comb begin
    in_tready       = (state_r == ST_IDLE);
    clr_nxt         = clr_r;
    next_slot_nxt   = next_slot_r;
    dir_we          = 1'b0;
    dir_waddr       = clr_r[IDX_W-1:0];
    dir_wdata       = '0;
    dir_raddr       = in_tdata[DIR_MSB -: IDX_W];
    pool_we         = 1'b0;
    pool_waddr      = clr_r;
    pool_wdata      = '0;
    pool_raddr      = {slot_diff[SLOT_W-1:0], tidx_r};
    res_addr_nxt    = res_addr_r;
    res_present_nxt = res_present_r;
    res_full_nxt    = res_full_r;
    unique case (state_r)
      ST_CLEAR: begin
        // dir index wraps and rewrites zeros until the pool is done
        dir_we  = 1'b1;
        pool_we = 1'b1;
        clr_nxt = clr_r + PA_W'(1);
      end
      ST_IDLE: ;
      ST_DIR: begin
        res_addr_nxt    = '0;
        res_present_nxt = 1'b0;
        res_full_nxt    = 1'b0;
        pool_wdata      = '{present: pflag_r, frame: pfn_r};
        if (kind_r == KIND_MAP) begin
          if (!dir_rdata_r.present) begin
            if (pool_empty) begin
              res_full_nxt = 1'b1;
            end else begin
              dir_we          = 1'b1;
              dir_waddr       = dir_raddr_r;
              dir_wdata       = '{present: 1'b1, frame: new_frame};
              pool_we         = 1'b1;
              pool_waddr      = {next_slot_r[SLOT_W-1:0], tidx_r};
              next_slot_nxt   = next_slot_r + CNT_W'(1);
              res_present_nxt = 1'b1;
            end
          end else if (slot_ok) begin
            pool_we         = 1'b1;
            pool_waddr      = {slot_diff[SLOT_W-1:0], tidx_r};
            res_present_nxt = 1'b1;
          end
        end
      end
      ST_TBL: begin
        if (pool_rdata_r.present) begin
          res_addr_nxt    = {pool_rdata_r.frame, offs_r};
          res_present_nxt = 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_rdata_r <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    pool_rdata_r <= pool_mem[pool_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      next_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_slot_r <= next_slot_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration register
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_frame_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == REG_POOL_FRAME) begin
      pool_frame_r <= cfg_pwdata[FRAME_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_POOL_FRAME) ? {12'd0, pool_frame_r} : 32'd0;

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      kind_r      <= in_tuser;
      dir_raddr_r <= in_tdata[DIR_MSB -: IDX_W];
      tidx_r      <= in_tdata[TBL_MSB -: IDX_W];
      offs_r      <= in_tdata[OFFS_W-1:0];
      pfn_r       <= in_tdata[63 -: FRAME_W];
      pflag_r     <= in_tdata[64];
    end
    res_addr_r    <= res_addr_nxt;
    res_present_r <= res_present_nxt;
    res_full_r    <= res_full_nxt;
    if (out_load) begin
      out_addr_r    <= res_addr_r;
      out_present_r <= res_present_r;
      out_full_r    <= res_full_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_full_r, out_present_r, out_addr_r};

  logic unused_ok;
  assign unused_ok = ^{cfg_paddr[1:0], cfg_pwdata[31:FRAME_W], in_tdata[79:65],
                       in_tdata[11:0] == 12'd0, in_tdata[63:32] == 32'd0,
                       ENTRY_W == $bits(tlpt_entry_t)};

endmodule

`default_nettype wire
